FILE: hw/rtl/trr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TFTP read receiver package
// Event, action, status and failure codes, configuration and queue item types.
// ----------------------------------------------------------------------------
package trr_pkg;

  // Queue depth between front and back
  localparam int unsigned QueueDepth = 2;

  // Defaults when an option is not requested
  localparam logic [15:0] DefBlockSize = 16'd512;
  localparam logic [7:0]  DefTimeout   = 8'd2;

  // Option bit positions in the acknowledged option mask
  localparam int unsigned OptBlksize = 0;
  localparam int unsigned OptTimeout = 1;
  localparam int unsigned OptTsize   = 2;
  localparam int unsigned OptWindow  = 3;

  // Raw event kind carried on the input stream
  typedef enum logic [2:0] {
    KIND_START   = 3'd0,
    KIND_DATA    = 3'd1,
    KIND_OACK    = 3'd2,
    KIND_ERROR   = 3'd3,
    KIND_TIMEOUT = 3'd4,
    KIND_OTHER   = 3'd5
  } kind_e;

  // Classified event as queued for the back end
  typedef enum logic [2:0] {
    EV_START,
    EV_DATA,
    EV_OACK,
    EV_ERROR,
    EV_TIMEOUT,
    EV_OTHER,
    EV_IGNORE
  } ev_e;

  typedef enum logic [2:0] {
    ACT_NONE        = 3'd0,
    ACT_SEND_RRQ    = 3'd1,
    ACT_SEND_ACK    = 3'd2,
    ACT_ERR_TID     = 3'd3,
    ACT_ERR_OPTIONS = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_RUNNING = 2'd0,
    ST_SUCCESS = 2'd1,
    ST_FAILED  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    FR_NONE          = 3'd0,
    FR_TIMED_OUT     = 3'd1,
    FR_SERVER_ERROR  = 3'd2,
    FR_BAD_OPTION    = 3'd3,
    FR_BAD_OPCODE    = 3'd4,
    FR_SIZE_MISMATCH = 3'd5
  } fail_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_REQ_BLOCK_SIZE  = 3'd0,
    CFG_REQ_TIMEOUT     = 3'd1,
    CFG_REQ_WINDOW_SIZE = 3'd2,
    CFG_REQ_TSIZE       = 3'd3,
    CFG_RETRY_LIMIT     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] req_block_size;
    logic [7:0]  req_timeout;
    logic [15:0] req_window_size;
    logic        req_tsize;
    logic [7:0]  retry_limit;
  } cfg_t;

  // One classified request on its way to the back end
  typedef struct packed {
    ev_e         ev;
    logic [15:0] peer_id;
    logic [15:0] data_block;
    logic [15:0] payload_length;
    logic [3:0]  option_mask;
    logic        option_bad;
    logic [15:0] blksize_value;
    logic [7:0]  timeout_value;
    logic [31:0] tsize_value;
  } item_t;

  // One result
  typedef struct packed {
    action_e     action;
    logic [15:0] ack_block;
    status_e     status;
    fail_e       fail_reason;
    logic [7:0]  timeout_now;
    logic        timeout_changed;
    logic        options_maybe_unsupported;
    logic [31:0] byte_total;
  } result_t;

endpackage

FILE: hw/rtl/trr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TFTP read receiver front end
// Classify incoming events and check OACK options against the request.
// ----------------------------------------------------------------------------
module trr_front import trr_pkg::*; (
  input  logic [2:0]  kind_i,
  input  logic [15:0] peer_id_i,
  input  logic [15:0] data_block_i,
  input  logic [15:0] payload_length_i,
  input  logic [3:0]  option_mask_i,
  input  logic [15:0] blksize_value_i,
  input  logic [7:0]  timeout_value_i,
  input  logic [31:0] tsize_value_i,
  input  cfg_t        cfg_i,
  output item_t       item_o
);

  logic [3:0] requested;

  // Build the mask of options this client asked for
  always_comb begin
    requested = '0;
    requested[OptBlksize] = (cfg_i.req_block_size != '0);
    requested[OptTimeout] = (cfg_i.req_timeout != '0);
    requested[OptTsize]   = cfg_i.req_tsize;
    requested[OptWindow]  = (cfg_i.req_window_size != '0);
  end

  // Map the raw kind onto an event class
  always_comb begin
    item_o = '0;
    unique case (kind_i)
      KIND_START:   item_o.ev = EV_START;
      KIND_DATA:    item_o.ev = EV_DATA;
      KIND_OACK:    item_o.ev = EV_OACK;
      KIND_ERROR:   item_o.ev = EV_ERROR;
      KIND_TIMEOUT: item_o.ev = EV_TIMEOUT;
      KIND_OTHER:   item_o.ev = EV_OTHER;
      default:      item_o.ev = EV_IGNORE;
    endcase
    item_o.peer_id        = peer_id_i;
    item_o.data_block     = data_block_i;
    item_o.payload_length = payload_length_i;
    item_o.option_mask    = option_mask_i;
    item_o.option_bad     = ((option_mask_i & ~requested) != '0);
    item_o.blksize_value  = blksize_value_i;
    item_o.timeout_value  = timeout_value_i;
    item_o.tsize_value    = tsize_value_i;
  end

endmodule

FILE: hw/rtl/trr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TFTP read receiver queue
// Short FIFO of classified requests between the front and back ends.
// ----------------------------------------------------------------------------
module trr_queue import trr_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t pop_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t             mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_item_o = mem_q[rd_ptr_q];

  // Advance pointers with wrap and track fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed requests
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: hw/rtl/trr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TFTP read receiver back end
// Transfer FSM: one queued request per cycle to the result register when free.
// ----------------------------------------------------------------------------
module trr_back import trr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    pop_o,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RUN,
    PH_OK,
    PH_FAIL
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] expected_block_q, expected_block_d;
  logic [15:0] last_block_q, last_block_d;
  logic [31:0] byte_count_q, byte_count_d;
  logic [7:0]  retry_count_q, retry_count_d;
  logic        peer_latched_q, peer_latched_d;
  logic [15:0] server_peer_q, server_peer_d;
  logic [15:0] active_block_size_q, active_block_size_d;
  logic [7:0]  active_timeout_q, active_timeout_d;
  logic [31:0] agreed_tsize_q, agreed_tsize_d;
  logic        last_sent_was_ack_q, last_sent_was_ack_d;
  logic [15:0] last_ack_block_q, last_ack_block_d;
  fail_e       fail_code_q, fail_code_d;
  logic        maybe_unsup_q, maybe_unsup_d;

  logic        out_valid_q;
  result_t     out_q;

  action_e     action;
  logic [15:0] ack_block;
  logic        tchg;
  logic        any_requested;
  logic        peer_mismatch;
  logic [32:0] byte_sum;
  status_e     status;

  // Take a request when the result register is free or draining
  assign pop_o       = item_valid_i && (!out_valid_q || res_ready_i);
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  assign any_requested = (cfg_i.req_block_size != '0) || (cfg_i.req_timeout != '0) ||
                         cfg_i.req_tsize || (cfg_i.req_window_size != '0);
  assign peer_mismatch = peer_latched_q && (item_i.peer_id != server_peer_q);
  assign byte_sum      = {1'b0, byte_count_q} + {17'd0, item_i.payload_length};

  // Apply one event to the transfer state
  always_comb begin
    phase_d             = phase_q;
    expected_block_d    = expected_block_q;
    last_block_d        = last_block_q;
    byte_count_d        = byte_count_q;
    retry_count_d       = retry_count_q;
    peer_latched_d      = peer_latched_q;
    server_peer_d       = server_peer_q;
    active_block_size_d = active_block_size_q;
    active_timeout_d    = active_timeout_q;
    agreed_tsize_d      = agreed_tsize_q;
    last_sent_was_ack_d = last_sent_was_ack_q;
    last_ack_block_d    = last_ack_block_q;
    fail_code_d         = fail_code_q;
    maybe_unsup_d       = maybe_unsup_q;
    action              = ACT_NONE;
    ack_block           = '0;
    tchg                = 1'b0;

    if (pop_o) begin
      unique case (item_i.ev) inside
        EV_START: begin
          phase_d             = PH_RUN;
          expected_block_d    = 16'd1;
          last_block_d        = '0;
          byte_count_d        = '0;
          retry_count_d       = '0;
          peer_latched_d      = 1'b0;
          server_peer_d       = '0;
          active_block_size_d = (cfg_i.req_block_size != '0) ? cfg_i.req_block_size
                                                             : DefBlockSize;
          active_timeout_d    = (cfg_i.req_timeout != '0) ? cfg_i.req_timeout : DefTimeout;
          agreed_tsize_d      = '0;
          last_sent_was_ack_d = 1'b0;
          last_ack_block_d    = '0;
          fail_code_d         = FR_NONE;
          maybe_unsup_d       = 1'b0;
          action              = ACT_SEND_RRQ;
        end
        EV_TIMEOUT: begin
          if (phase_q == PH_RUN) begin
            if (retry_count_q == cfg_i.retry_limit) begin
              phase_d     = PH_FAIL;
              fail_code_d = FR_TIMED_OUT;
            end else begin
              retry_count_d = retry_count_q + 1'b1;
              if (last_sent_was_ack_q) begin
                action    = ACT_SEND_ACK;
                ack_block = last_ack_block_q;
              end else begin
                action = ACT_SEND_RRQ;
              end
            end
          end
        end
        EV_DATA, EV_OACK, EV_ERROR, EV_OTHER: begin
          if (phase_q == PH_RUN) begin
            retry_count_d = '0;
            if (!peer_latched_q) begin
              peer_latched_d = 1'b1;
              server_peer_d  = item_i.peer_id;
            end
            if (peer_mismatch) begin
              action = ACT_ERR_TID;
            end else begin
              case (item_i.ev)
                EV_DATA: begin
                  last_block_d = item_i.data_block;
                  if (item_i.data_block == expected_block_q) begin
                    expected_block_d    = expected_block_q + 1'b1;
                    byte_count_d        = byte_sum[32] ? '1 : byte_sum[31:0];
                    action              = ACT_SEND_ACK;
                    ack_block           = item_i.data_block;
                    last_sent_was_ack_d = 1'b1;
                    last_ack_block_d    = item_i.data_block;
                    if (item_i.payload_length < active_block_size_q) begin
                      if (cfg_i.req_tsize && (byte_count_d != agreed_tsize_q)) begin
                        phase_d     = PH_FAIL;
                        fail_code_d = FR_SIZE_MISMATCH;
                      end else begin
                        phase_d = PH_OK;
                      end
                    end
                  end
                end
                EV_OACK: begin
                  if (item_i.option_bad) begin
                    action      = ACT_ERR_OPTIONS;
                    phase_d     = PH_FAIL;
                    fail_code_d = FR_BAD_OPTION;
                  end else begin
                    if (item_i.option_mask[OptBlksize]) begin
                      active_block_size_d = item_i.blksize_value;
                    end
                    if (item_i.option_mask[OptTimeout]) begin
                      tchg             = (item_i.timeout_value != active_timeout_q);
                      active_timeout_d = item_i.timeout_value;
                    end
                    if (item_i.option_mask[OptTsize]) begin
                      agreed_tsize_d = item_i.tsize_value;
                    end
                    action              = ACT_SEND_ACK;
                    ack_block           = last_block_q;
                    last_sent_was_ack_d = 1'b1;
                    last_ack_block_d    = last_block_q;
                  end
                end
                EV_ERROR: begin
                  if ((last_block_q == '0) && any_requested) begin
                    maybe_unsup_d = 1'b1;
                  end
                  phase_d     = PH_FAIL;
                  fail_code_d = FR_SERVER_ERROR;
                end
                default: begin
                  phase_d     = PH_FAIL;
                  fail_code_d = FR_BAD_OPCODE;
                end
              endcase
            end
          end
        end
        EV_IGNORE: begin
          action = ACT_NONE;
        end
        default: begin
          action = ACT_NONE;
        end
      endcase
    end
  end

  // Map the next phase onto the reported status
  always_comb begin
    unique case (phase_d)
      PH_OK:   status = ST_SUCCESS;
      PH_FAIL: status = ST_FAILED;
      default: status = ST_RUNNING;
    endcase
  end

  // Hold transfer state and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q             <= PH_IDLE;
      expected_block_q    <= 16'd1;
      last_block_q        <= '0;
      byte_count_q        <= '0;
      retry_count_q       <= '0;
      peer_latched_q      <= 1'b0;
      server_peer_q       <= '0;
      active_block_size_q <= DefBlockSize;
      active_timeout_q    <= DefTimeout;
      agreed_tsize_q      <= '0;
      last_sent_was_ack_q <= 1'b0;
      last_ack_block_q    <= '0;
      fail_code_q         <= FR_NONE;
      maybe_unsup_q       <= 1'b0;
      out_valid_q         <= 1'b0;
    end else begin
      phase_q             <= phase_d;
      expected_block_q    <= expected_block_d;
      last_block_q        <= last_block_d;
      byte_count_q        <= byte_count_d;
      retry_count_q       <= retry_count_d;
      peer_latched_q      <= peer_latched_d;
      server_peer_q       <= server_peer_d;
      active_block_size_q <= active_block_size_d;
      active_timeout_q    <= active_timeout_d;
      agreed_tsize_q      <= agreed_tsize_d;
      last_sent_was_ack_q <= last_sent_was_ack_d;
      last_ack_block_q    <= last_ack_block_d;
      fail_code_q         <= fail_code_d;
      maybe_unsup_q       <= maybe_unsup_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q.action                    <= action;
      out_q.ack_block                 <= ack_block;
      out_q.status                    <= status;
      out_q.fail_reason               <= fail_code_d;
      out_q.timeout_now               <= active_timeout_d;
      out_q.timeout_changed           <= tchg;
      out_q.options_maybe_unsupported <= maybe_unsup_d;
      out_q.byte_total                <= byte_count_d;
    end
  end

  // A successful transfer never carries a failure reason
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status == ST_SUCCESS)) |-> (out_q.fail_reason == FR_NONE))
    else $error("success result with failure reason");

  // A timeout change only comes with the ACK of an OACK
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.timeout_changed) |-> (out_q.action == ACT_SEND_ACK))
    else $error("timeout change without ACK");

  // A start always leaves the transfer running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && (item_i.ev == EV_START)) |=> (phase_q == PH_RUN))
    else $error("start did not enter run phase");

  // Nothing is counted before the first start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> ((byte_count_q == '0) && !peer_latched_q))
    else $error("idle phase with transfer state");

endmodule

FILE: hw/rtl/tftp_read_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TFTP read receiver
// Client-side TFTP read engine: events in, one action and status result out.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake                  Payload
//  s_axis    in   tvalid/tready              tuser kind, tdata packet fields
//  m_axis    out  tvalid/tready              tuser action, tdata status fields
//  cfg       in   cfg_valid_i/cfg_ready_o    cfg_index_i register, cfg_data_i
//
//  One event per cycle sustained while m_axis_tready holds; an accepted
//  event is written into the queue, then the back-end state update loads
//  its result into the result register.
//  The back-end state update is the loop that sets the rate.
//  A classified-event queue of QueueDepth entries lets the input keep flowing
//  while a result waits on m_axis_tready.
//  Reset clears the queue, the transfer state and the configuration registers.
//  Configuration is always ready.
// ----------------------------------------------------------------------------
module tftp_read_receiver import trr_pkg::*; #(
  parameter int unsigned QueueDepth = trr_pkg::QueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Event stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // kind[2:0]
  input  logic [2:0]   s_axis_tuser,
  // peer_id[15:0], data_block[31:16], payload_length[47:32],
  // option_mask[51:48], blksize_value[67:52], timeout_value[75:68],
  // tsize_value[107:76], windowsize_value[123:108], zero[127:124]
  input  logic [127:0] s_axis_tdata,
  // Result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // action[2:0]
  output logic [2:0]   m_axis_tuser,
  // ack_block[15:0], status[17:16], fail_reason[20:18], timeout_now[28:21],
  // timeout_changed[29], options_maybe_unsupported[30],
  // byte_total[62:31], zero[63]
  output logic [63:0]  m_axis_tdata,
  // Configuration writes
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);

  cfg_t    cfg_q;
  item_t   front_item;
  item_t   queue_item;
  logic    queue_full;
  logic    queue_valid;
  logic    queue_pop;
  logic    push;
  result_t result;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !queue_full;
  assign push          = s_axis_tvalid && s_axis_tready;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_REQ_BLOCK_SIZE:  cfg_q.req_block_size  <= cfg_data_i;
        CFG_REQ_TIMEOUT:     cfg_q.req_timeout     <= cfg_data_i[7:0];
        CFG_REQ_WINDOW_SIZE: cfg_q.req_window_size <= cfg_data_i;
        CFG_REQ_TSIZE:       cfg_q.req_tsize       <= cfg_data_i[0];
        CFG_RETRY_LIMIT:     cfg_q.retry_limit     <= cfg_data_i[7:0];
        default:             cfg_q                 <= cfg_q;
      endcase
    end
  end

  trr_front u_front (
    .kind_i           (s_axis_tuser),
    .peer_id_i        (s_axis_tdata[15:0]),
    .data_block_i     (s_axis_tdata[31:16]),
    .payload_length_i (s_axis_tdata[47:32]),
    .option_mask_i    (s_axis_tdata[51:48]),
    .blksize_value_i  (s_axis_tdata[67:52]),
    .timeout_value_i  (s_axis_tdata[75:68]),
    .tsize_value_i    (s_axis_tdata[107:76]),
    .cfg_i            (cfg_q),
    .item_o           (front_item)
  );

  trr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (front_item),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .pop_item_o  (queue_item)
  );

  trr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (queue_valid),
    .item_i       (queue_item),
    .pop_o        (queue_pop),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (result)
  );

  // Pack the result fields
  assign m_axis_tuser = result.action;
  assign m_axis_tdata = {1'b0,
                         result.byte_total,
                         result.options_maybe_unsupported,
                         result.timeout_changed,
                         result.timeout_now,
                         result.fail_reason,
                         result.status,
                         result.ack_block};

endmodule
